### rtl/ttws_pkg.sv
// Shared types and constants for the two-tone wavetable synthesizer.
// No dependencies; imported by ttws_step_mod, two_tone_wavetable_synth and the testbench.
package ttws_pkg;

    localparam int STEP_W         = 26;
    localparam int LEVEL_W        = 12;
    localparam int DUTY_W         = 12;
    localparam int SAMPLE_W       = 16;
    localparam int CFG_IDX_W      = 1;
    localparam int DUTY_OFFSET    = 1200;
    localparam int SINE_AMPLITUDE = 32767;
    localparam int VOLUME_SHIFT   = 18;
    localparam int SETTLE_W       = 2;
    localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd3;
    localparam longint unsigned HALF_PI_Q62 = 64'h6487ED5110B4611A;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_A = 1'b0,
        REG_STEP_B = 1'b1
    } cfg_reg_t;

endpackage

### rtl/two_tone_wavetable_synth.sv
// Two-channel DDS: phase accumulators, sine ROM, volume scaling to a PWM duty value.
// Depends on ttws_pkg and ttws_step_mod.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------
//   input    | in_valid / in_stall  | level [11:0]
//   output   | out_valid / out_stall| duty [11:0]
//   config   | cfg_we               | cfg_index [0:0], cfg_wdata [25:0]
//
// One item per cycle while in_stall is low; each item passes three registered stages
// (sine ROM read, add and multiply, shift and offset) before out_valid rises.
// After reset and after every step write, in_stall holds while the step is reduced
// modulo the table length.
// A stalled output holds; the three stages fill up before in_stall rises.
module two_tone_wavetable_synth
    import ttws_pkg::*;
#(
    parameter int TABLE_SIZE    = 1000,
    parameter int FRACTION_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [LEVEL_W-1:0]   level,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [DUTY_W-1:0]    duty,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [STEP_W-1:0]    cfg_wdata
);

    localparam int IDX_W  = $clog2(TABLE_SIZE);
    localparam int PW     = IDX_W + FRACTION_BITS;
    localparam int SUM_W  = SAMPLE_W + 1;
    localparam int PROD_W = SUM_W + LEVEL_W + 1;
    localparam logic [PW:0] LIMIT = (PW + 1)'(TABLE_SIZE) << FRACTION_BITS;

    typedef logic signed [SAMPLE_W-1:0] rom_t [TABLE_SIZE];

    function automatic longint unsigned mul_q62(input longint unsigned a,
                                                input longint unsigned b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    function automatic longint unsigned series_div(input longint unsigned v, input int i);
        longint unsigned r;
        case (i)
            3:       r = v / 64'd6;
            5:       r = v / 64'd20;
            7:       r = v / 64'd42;
            9:       r = v / 64'd72;
            11:      r = v / 64'd110;
            13:      r = v / 64'd156;
            15:      r = v / 64'd210;
            17:      r = v / 64'd272;
            19:      r = v / 64'd342;
            21:      r = v / 64'd420;
            23:      r = v / 64'd506;
            25:      r = v / 64'd600;
            27:      r = v / 64'd702;
            29:      r = v / 64'd812;
            default: r = v;
        endcase
        return r;
    endfunction

    // trunc(32767 * sin(2*pi*k/TABLE_SIZE)), Q62 Taylor series
    function automatic logic signed [SAMPLE_W-1:0] sine_entry(input int k);
        longint unsigned n;
        longint unsigned m;
        longint unsigned mag;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        logic            neg;
        logic            sub;
        n   = longint'(TABLE_SIZE);
        m   = 4 * longint'(k);
        neg = 1'b0;
        mag = 0;
        if (m >= 2 * n)
        begin
            neg = 1'b1;
            m   = m - 2 * n;
        end
        if (m > n)
            m = 2 * n - m;
        if (m == n)
            mag = longint'(SINE_AMPLITUDE);
        else if (m != 0)
        begin
            x = (HALF_PI_Q62 / TABLE_SIZE) * m + ((HALF_PI_Q62 % TABLE_SIZE) * m) / TABLE_SIZE;
            x2   = mul_q62(x, x);
            term = x;
            sum  = x;
            sub  = 1'b1;
            for (int i = 3; i <= 29; i += 2)
            begin
                term = series_div(mul_q62(term, x2), i);
                if (sub)
                    sum = sum - term;
                else
                    sum = sum + term;
                sub = !sub;
            end
            mag = ((sum >> 32) * 64'd32767
                   + (((sum & 64'hFFFF_FFFF) * 64'd32767) >> 32)) >> 30;
        end
        return neg ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
    endfunction

    function automatic rom_t build_rom();
        rom_t r;
        for (int k = 0; k < TABLE_SIZE; k++)
            r[k] = sine_entry(k);
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [STEP_W-1:0]          step_a_reg;
    logic [STEP_W-1:0]          step_b_reg;
    logic [PW-1:0]              step_mod_a;
    logic [PW-1:0]              step_mod_b;
    logic [PW-1:0]              phase_a_reg;
    logic [PW-1:0]              phase_b_reg;
    logic [PW-1:0]              phase_a_next;
    logic [PW-1:0]              phase_b_next;
    logic [PW:0]                sum_a;
    logic [PW:0]                sum_b;
    logic [SETTLE_W-1:0]        busy_reg;
    logic [SETTLE_W-1:0]        busy_next;
    logic                       clr_a;
    logic                       clr_b;
    logic                       accept;
    logic                       en1;
    logic                       en2;
    logic                       en_out;
    logic                       v1_reg;
    logic                       v2_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] rom_a_reg;
    logic signed [SAMPLE_W-1:0] rom_b_reg;
    logic [LEVEL_W-1:0]         level_reg;
    logic signed [SUM_W-1:0]    samp;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic [DUTY_W-1:0]          duty_next;
    logic [DUTY_W-1:0]          duty_reg;

    ttws_step_mod #(
        .TABLE_SIZE    (TABLE_SIZE),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mod_a (
        .clk      (clk),
        .step     (step_a_reg),
        .step_mod (step_mod_a)
    );

    ttws_step_mod #(
        .TABLE_SIZE    (TABLE_SIZE),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mod_b (
        .clk      (clk),
        .step     (step_b_reg),
        .step_mod (step_mod_b)
    );

    // configuration decode
    always_comb
    begin
        clr_a = 1'b0;
        clr_b = 1'b0;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_STEP_A: clr_a = (cfg_wdata == '0);
                REG_STEP_B: clr_b = (cfg_wdata == '0);
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        if (cfg_we)
            busy_next = SETTLE_CYCLES;
        else if (busy_reg != '0)
            busy_next = busy_reg - 1'b1;
        else
            busy_next = busy_reg;
    end

    assign en_out   = !out_valid_reg || !out_stall;
    assign en2      = !v2_reg || en_out;
    assign en1      = !v1_reg || en2;
    assign in_stall = !en1 || (busy_reg != '0);
    assign accept   = in_valid && !in_stall;

    assign sum_a        = (PW + 1)'(phase_a_reg) + (PW + 1)'(step_mod_a);
    assign sum_b        = (PW + 1)'(phase_b_reg) + (PW + 1)'(step_mod_b);
    assign phase_a_next = (sum_a >= LIMIT) ? PW'(sum_a - LIMIT) : PW'(sum_a);
    assign phase_b_next = (sum_b >= LIMIT) ? PW'(sum_b - LIMIT) : PW'(sum_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_a_reg    <= '0;
            step_b_reg    <= '0;
            phase_a_reg   <= '0;
            phase_b_reg   <= '0;
            busy_reg      <= SETTLE_CYCLES;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_STEP_A: step_a_reg <= cfg_wdata;
                    REG_STEP_B: step_b_reg <= cfg_wdata;
                    default:    ;
                endcase
            end
            if (clr_a)
                phase_a_reg <= '0;
            else if (accept)
                phase_a_reg <= phase_a_next;
            if (clr_b)
                phase_b_reg <= '0;
            else if (accept)
                phase_b_reg <= phase_b_next;
            if (en1)
                v1_reg <= accept;
            if (en2)
                v2_reg <= v1_reg;
            if (en_out)
                out_valid_reg <= v2_reg;
        end
    end

    // sine ROM, two registered read ports
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rom_a_reg <= SINE_ROM[phase_a_next[PW-1:FRACTION_BITS]];
            rom_b_reg <= SINE_ROM[phase_b_next[PW-1:FRACTION_BITS]];
            level_reg <= level;
        end
    end

    assign samp      = SUM_W'(rom_a_reg) + SUM_W'(rom_b_reg);
    assign prod_next = PROD_W'(samp) * PROD_W'(signed'({1'b0, level_reg}));
    assign duty_next = DUTY_W'(prod_reg >>> VOLUME_SHIFT) + DUTY_W'(DUTY_OFFSET);

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
            prod_reg <= prod_next;
        if (en_out && v2_reg)
            duty_reg <= duty_next;
    end

    assign out_valid = out_valid_reg;
    assign duty      = duty_reg;

`ifndef SYNTHESIS
    a_cfg_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> in_stall)
        else $error("input not stalled after step write");

    a_phase_a_range: assert property (@(posedge clk) disable iff (!rst_n)
        (PW + 1)'(phase_a_reg) < LIMIT)
        else $error("phase_a out of range");

    a_step_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == '0 |-> ((PW + 1)'(step_mod_a) < LIMIT && (PW + 1)'(step_mod_b) < LIMIT))
        else $error("reduced step out of range");

    a_clear_a: assert property (@(posedge clk) disable iff (!rst_n)
        clr_a |=> phase_a_reg == '0)
        else $error("zero step write did not clear phase_a");

    a_stage1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && !en2 |=> v1_reg && $stable(level_reg) && $stable(rom_a_reg))
        else $error("stage 1 item lost while blocked");
`endif

endmodule

### rtl/ttws_step_mod.sv
// Reduces a phase step modulo TABLE_SIZE << FRACTION_BITS in a registered pipeline.
// Reciprocal multiply, back-multiply and one correction. Uses ttws_pkg.
module ttws_step_mod
    import ttws_pkg::*;
#(
    parameter int TABLE_SIZE    = 1000,
    parameter int FRACTION_BITS = 16
)
(
    input  logic                                          clk,
    input  logic [STEP_W-1:0]                             step,
    output logic [$clog2(TABLE_SIZE)+FRACTION_BITS-1:0]   step_mod
);

    localparam int PW     = $clog2(TABLE_SIZE) + FRACTION_BITS;
    localparam int MW     = PW + 1;
    localparam int K      = STEP_W + PW;
    localparam int RW     = STEP_W + 1;
    localparam int PROD_W = K + STEP_W;
    localparam longint unsigned LIMIT_L = longint'(TABLE_SIZE) << FRACTION_BITS;
    localparam longint unsigned RECIP_L = (64'd1 << K) / LIMIT_L;
    localparam logic [RW-1:0] RECIP     = RW'(RECIP_L);
    localparam logic [MW-1:0] LIMIT_M   = MW'(LIMIT_L);

    logic [PROD_W-1:0] quot_prod;
    logic [STEP_W-1:0] quot_reg;
    logic [STEP_W-1:0] step_d_reg;
    logic [MW-1:0]     rem_reg;
    logic [MW-1:0]     rem_next;
    logic [PW-1:0]     step_mod_reg;
    logic [PW-1:0]     step_mod_next;

    assign quot_prod = PROD_W'(step) * PROD_W'(RECIP);

    // estimate is low by at most one, so the remainder stays below twice the limit
    assign rem_next      = MW'(step_d_reg) - MW'(quot_reg) * LIMIT_M;
    assign step_mod_next = (rem_reg >= LIMIT_M) ? PW'(rem_reg - LIMIT_M) : PW'(rem_reg);

    always_ff @(posedge clk)
    begin
        quot_reg     <= quot_prod[K +: STEP_W];
        step_d_reg   <= step;
        rem_reg      <= rem_next;
        step_mod_reg <= step_mod_next;
    end

    assign step_mod = step_mod_reg;

endmodule

### tb/sv/tb_two_tone_wavetable_synth.sv
// Self-checking testbench for two_tone_wavetable_synth: a queue-fed driver and a clocked
// monitor check every duty item against a built-in phase and sine-table predictor.
// Depends on ttws_pkg and the two_tone_wavetable_synth RTL.
`timescale 1ns / 1ps

module tb_two_tone_wavetable_synth;
    import ttws_pkg::*;

    localparam int TABLE_LEN  = 1000;
    localparam int FRAC_BITS  = 16;
    localparam longint unsigned PHASE_WRAP = 64'd1000 << FRAC_BITS;
    localparam logic [STEP_W-1:0] QUARTER_STEP = 26'd16384000;
    localparam logic [STEP_W-1:0] MAX_STEP     = 26'd65535999;
    localparam logic [STEP_W-1:0] FULL_STEP    = '1;
    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 8;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [LEVEL_W-1:0]   level = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [DUTY_W-1:0]    duty;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [STEP_W-1:0]    cfg_wdata = '0;

    logic [LEVEL_W-1:0] level_queue[$];
    logic [DUTY_W-1:0]  pending_duty[$];
    logic [DUTY_W-1:0]  want_duty;

    int sine_tab[TABLE_LEN];
    longint unsigned acc_a = 0;
    longint unsigned acc_b = 0;
    longint unsigned inc_a = 0;
    longint unsigned inc_b = 0;

    int idle_pct = 0;
    int stall_pct = 0;
    bit hold_go = 1'b0;
    logic hold_rx = 1'b0;
    int quiet_cycles = 0;
    int mismatches = 0;
    int levels_sent = 0;
    int duties_checked = 0;
    int step_writes = 0;

    two_tone_wavetable_synth u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .level     (level),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .duty      (duty),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // (a * b) >> 62 on 64-bit operands
    function automatic longint unsigned q62_mul(longint unsigned a, longint unsigned b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // trunc(32767 * sin(2*pi*k/TABLE_LEN)) by a Q62 Taylor series
    function automatic int sine_value(int k);
        longint unsigned n, m, x, x2, term, sum, mag, i;
        bit neg;
        n = 64'(TABLE_LEN);
        m = 64'(4 * k);
        neg = 1'b0;
        if (m >= 2 * n)
        begin
            neg = 1'b1;
            m = m - 2 * n;
        end
        if (m > n)
            m = 2 * n - m;
        if (m == n)
            mag = 64'(SINE_AMPLITUDE);
        else if (m == 0)
            mag = 0;
        else
        begin
            x = (HALF_PI_Q62 / n) * m + ((HALF_PI_Q62 % n) * m) / n;
            x2 = q62_mul(x, x);
            term = x;
            sum = x;
            for (i = 3; i <= 29; i = i + 2)
            begin
                term = q62_mul(term, x2) / ((i - 1) * i);
                if (((i - 3) / 2) % 2 == 0)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            mag = ((sum >> 32) * SINE_AMPLITUDE
                   + (((sum & 64'hFFFF_FFFF) * SINE_AMPLITUDE) >> 32)) >> 30;
        end
        return neg ? -int'(mag) : int'(mag);
    endfunction

    // advances both phases and returns the duty for one volume item
    function automatic logic [DUTY_W-1:0] next_duty(logic [LEVEL_W-1:0] lvl);
        longint unsigned ia, ib;
        longint prod, scaled;
        logic [DUTY_W-1:0] d;
        acc_a = (acc_a + inc_a) % PHASE_WRAP;
        acc_b = (acc_b + inc_b) % PHASE_WRAP;
        ia = acc_a >> FRAC_BITS;
        ib = acc_b >> FRAC_BITS;
        if (ia >= TABLE_LEN)
            ia = 0;
        if (ib >= TABLE_LEN)
            ib = 0;
        prod = longint'(sine_tab[ia] + sine_tab[ib]) * longint'(lvl);
        scaled = prod >>> VOLUME_SHIFT;
        d = DUTY_W'(scaled + DUTY_OFFSET);
        return d;
    endfunction

    function automatic logic [STEP_W-1:0] pick_step();
        case ($urandom_range(9))
            0: return '0;
            1: return MAX_STEP;
            2: return FULL_STEP;
            3: return STEP_W'($urandom);
            4: return QUARTER_STEP;
            default: return STEP_W'($urandom_range(20000000, 1));
        endcase
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_level();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return LEVEL_W'($urandom_range(4095));
        endcase
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task automatic set_step(cfg_reg_t idx, logic [STEP_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_STEP_A)
        begin
            inc_a = 64'(val);
            if (val == 0)
                acc_a = 0;
        end
        else
        begin
            inc_b = 64'(val);
            if (val == 0)
                acc_b = 0;
        end
        step_writes++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (level_queue.size() != 0 || in_valid || pending_duty.size() != 0);
    endtask

    task automatic queue_levels(int count);
        repeat (count)
            level_queue.push_back(pick_level());
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            level    <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                pending_duty.push_back(next_duty(level));
                levels_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (level_queue.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    in_valid <= 1'b1;
                    level    <= level_queue.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_duty.size() == 0)
                    report_mismatch($sformatf("duty %0d with nothing expected", duty));
                else
                begin
                    want_duty = pending_duty.pop_front();
                    duties_checked++;
                    if (duty !== want_duty)
                        report_mismatch($sformatf("duty %0d, expected %0d", duty, want_duty));
                end
            end
            out_stall <= hold_rx || ($urandom_range(99) < stall_pct);
        end
    end

    // long receiver hold-off
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES)
            @(posedge clk);
        hold_rx <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
                $display("FAIL two_tone_wavetable_synth");
                $finish;
            end
        end
    end

    initial
    begin
        for (int k = 0; k < TABLE_LEN; k++)
            sine_tab[k] = sine_value(k);
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // steps at zero: duty sits at the offset
        level_queue.push_back(12'd0);
        level_queue.push_back(12'd4095);
        level_queue.push_back(12'd1);
        wait_drained();

        // quarter-cycle steps hit the positive peak, zero, the negative peak, zero
        set_step(REG_STEP_A, QUARTER_STEP);
        set_step(REG_STEP_B, QUARTER_STEP);
        repeat (4)
            level_queue.push_back(12'd4095);
        wait_drained();

        // zero write clears phase B
        set_step(REG_STEP_B, '0);
        level_queue.push_back(12'd4095);
        level_queue.push_back(12'd4095);
        wait_drained();

        // nonzero writes keep phase; out-of-range step wraps by full remainder
        set_step(REG_STEP_A, FULL_STEP);
        set_step(REG_STEP_B, MAX_STEP);
        level_queue.push_back(12'd4095);
        level_queue.push_back(12'hAAA);
        level_queue.push_back(12'h555);
        level_queue.push_back(12'd4095);
        level_queue.push_back(12'd0);
        wait_drained();

        set_step(REG_STEP_A, 26'd1);
        queue_levels(3);
        wait_drained();

        for (int p = 0; p < 8; p++)
        begin
            repeat (DRAIN_CYCLES)
                @(negedge clk);
            if ($urandom_range(3) != 0)
                set_step(REG_STEP_A, pick_step());
            if ($urandom_range(3) != 0)
                set_step(REG_STEP_B, pick_step());
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 56; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 56; end
                default: begin idle_pct = 28; stall_pct = 28; end
            endcase
            if (p == 4)
                hold_go = 1'b1;
            queue_levels(110);
            wait_drained();
            queue_levels(105);
            wait_drained();
        end
        idle_pct = 0;
        stall_pct = 0;

        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (pending_duty.size() != 0)
            report_mismatch($sformatf("%0d duty items never arrived", pending_duty.size()));
        $display("Run: %0d volume items, %0d duty items checked, %0d step writes,",
                 levels_sent, duties_checked, step_writes);
        $display("     sine peaks, phase clears, step wrap, long output hold-off; %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("PASS two_tone_wavetable_synth");
        else
            $display("FAIL two_tone_wavetable_synth");
        $finish;
    end

endmodule

### filelist.f
rtl/ttws_pkg.sv
rtl/ttws_step_mod.sv
rtl/two_tone_wavetable_synth.sv
tb/sv/tb_two_tone_wavetable_synth.sv
